>>> hw/rtl/sdl_pkg.sv
// Shared opcodes, status codes, widths and command type for the sorted deque list unit.
`timescale 1ns / 1ps

package sdl_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } sdl_cmd_type;

endpackage

>>> hw/rtl/sdl_ctrl.sv
// Controller state machine: sequences capture, execute and result load per transfer.
`timescale 1ns / 1ps

module sdl_ctrl
   import sdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sdl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       load_ok;

   always_comb begin
      load_ok      = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_ready);
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.execute  = (state_ff == S_EXEC);
      cmd.load     = load_ok;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load_ok) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load_ok) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/sdl_datapath.sv
// Datapath: chain of compare-and-shift entry cells, entry count and result registers.
`timescale 1ns / 1ps

module sdl_datapath
   import sdl_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  sdl_cmd_type                cmd,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic signed [VALUE_W-1:0]  rsp_first_value,
   output logic signed [VALUE_W-1:0]  rsp_last_value
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [OPCODE_W-1:0]  op_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic [VALUE_W-1:0]   cells_ff [CAPACITY];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [CAPACITY-1:0]  lt;
   logic [CAPACITY-1:0]  pre;
   logic                 full;
   logic                 empty;
   logic                 is_push;
   logic                 is_pop;
   logic                 push_ok;
   logic                 pop_ok;
   logic [VALUE_W-1:0]   last_sel;
   logic [EW-1:0]        count_ext;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [VALUE_W-1:0]   rsp_first_ff;
   logic [VALUE_W-1:0]   rsp_last_ff;

   always_comb begin
      full    = (count_ff == CW'(CAPACITY));
      empty   = (count_ff == '0);
      is_push = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK) || (op_ff == OP_INSERT);
      is_pop  = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK);
      push_ok = is_push && !full;
      pop_ok  = is_pop && !empty;
      if (is_push && full) begin
         status_in = STAT_FULL;
      end else if (is_pop && empty) begin
         status_in = STAT_EMPTY;
      end else begin
         status_in = STAT_DONE;
      end
      if (push_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         localparam int PREV = (gi == 0) ? 0 : gi - 1;
         localparam int NEXT = (gi == CAPACITY - 1) ? gi : gi + 1;
         localparam logic [CAPACITY-1:0] LOWM = {CAPACITY{1'b1}} >> (CAPACITY - gi);
         logic               we;
         logic [VALUE_W-1:0] cell_in;

         assign lt[gi]  = (CW'(gi) < count_ff) &&
                          ($signed(cells_ff[gi]) < $signed(val_ff));
         assign pre[gi] = &(lt | ~LOWM);

         always_comb begin
            we      = 1'b0;
            cell_in = cells_ff[gi];
            case (op_ff)
               OP_PUSH_FRONT: begin
                  we      = push_ok;
                  cell_in = (gi == 0) ? val_ff : cells_ff[PREV];
               end
               OP_PUSH_BACK: begin
                  we      = push_ok && (count_ff == CW'(gi));
                  cell_in = val_ff;
               end
               OP_INSERT: begin
                  we      = push_ok && (!pre[gi] || !lt[gi]);
                  cell_in = pre[gi] ? val_ff : cells_ff[PREV];
               end
               OP_POP_FRONT: begin
                  we      = pop_ok && (gi != CAPACITY - 1);
                  cell_in = cells_ff[NEXT];
               end
               default: begin
                  we      = 1'b0;
                  cell_in = cells_ff[gi];
               end
            endcase
         end

         always_ff @(posedge clock) begin
            if (cmd.execute && we) cells_ff[gi] <= cell_in;
         end
      end
   endgenerate

   always_comb begin
      last_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         last_sel = last_sel | (cells_ff[i] & {VALUE_W{count_ff == CW'(i + 1)}});
      end
      count_ext = EW'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         val_ff <= req_value;
      end
      if (cmd.execute) status_ff <= status_in;
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
         rsp_first_ff  <= empty ? '0 : cells_ff[0];
         rsp_last_ff   <= last_sel;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_first_value = rsp_first_ff;
   assign rsp_last_value  = rsp_last_ff;

endmodule

>>> hw/rtl/sorted_deque_list_unit.sv
// Each request holds the unit through the capture at the request transfer, an execute step
// in which the compare-and-shift cell chain applies the whole push, sorted insert or pop to
// all entries at once, and a load of the result register, which makes the result valid. The
// load waits while an earlier result still sits unaccepted in the output register; once the
// load is done the next request is taken, even while that result still waits to transfer.
// The list holds up to CAPACITY signed 32-bit entries, front first; sorted insert places a
// value before the first entry that is not less than it. A push to a full list and a pop
// from an empty list leave the list unchanged and report full or empty; first and last read
// zero when empty.
`timescale 1ns / 1ps

module sorted_deque_list_unit
   import sdl_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic signed [VALUE_W-1:0]  rsp_first_value,
   output logic signed [VALUE_W-1:0]  rsp_last_value
);

   sdl_cmd_type cmd;

   sdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sdl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_first_value (rsp_first_value),
      .rsp_last_value  (rsp_last_value)
   );

endmodule

>>> hw/rtl/sdl_checker.sv
// Port-level checker for the sorted deque list unit, bound to the top level.
`timescale 1ns / 1ps

module sdl_checker
   import sdl_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [STATUS_W-1:0]        rsp_status,
   input logic [COUNT_W-1:0]         rsp_entry_count,
   input logic signed [VALUE_W-1:0]  rsp_first_value,
   input logic signed [VALUE_W-1:0]  rsp_last_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_count) && $stable(rsp_first_value) && $stable(rsp_last_value))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_count == '0) && (CAPACITY < 32) |->
      (rsp_first_value == '0) && (rsp_last_value == '0))
      else $error("empty list reports nonzero ends");

   a_flag_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status != STAT_FULL) || (rsp_entry_count == 5'(CAPACITY % 32))) &&
      ((rsp_status != STAT_EMPTY) || (rsp_entry_count == '0)))
      else $error("status flag disagrees with count");

   a_single_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_count == 5'd1) && (CAPACITY < 32) |->
      rsp_first_value == rsp_last_value)
      else $error("single entry with different ends");

endmodule

bind sorted_deque_list_unit sdl_checker #(
   .CAPACITY (CAPACITY)
) u_sdl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_first_value (rsp_first_value),
   .rsp_last_value  (rsp_last_value)
);

>>> bench/tb.sv
// Self-checking bench for the sorted deque list unit: directed and random list operations.
`timescale 1ns / 1ps

module tb
   import sdl_pkg::*;
();

   localparam int CAPACITY    = 16;
   localparam int ITEM_TARGET = 1900;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 8;

   localparam logic [OPCODE_W-1:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RSVD_MID   = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RSVD_LAST  = 3'd7;

   localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
      logic                drain;
   } list_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [VALUE_W-1:0]  first_value;
      logic [VALUE_W-1:0]  last_value;
   } list_view_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_W-1:0]       req_opcode = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic signed [VALUE_W-1:0] rsp_first_value;
   logic signed [VALUE_W-1:0] rsp_last_value;

   list_op_type   op_backlog[$];
   list_view_type expected_views[$];

   logic signed [VALUE_W-1:0] list_copy [CAPACITY];
   int                        list_len = 0;

   logic        req_taken = 1'b0;
   list_op_type next_op;
   int          burst_left = 8;
   int          gap_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  stall_pos = '0;
   int          fault_count = 0;
   int          idle_cycles = 0;

   sorted_deque_list_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_first_value (rsp_first_value),
      .rsp_last_value  (rsp_last_value)
   );

   always #10 clock = ~clock;

   function automatic list_view_type apply_list_op(logic [OPCODE_W-1:0] op,
                                                   logic signed [VALUE_W-1:0] v);
      list_view_type view;
      int            pos;
      int            i;
      view.status = STAT_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT) begin
         if (list_len >= CAPACITY) begin
            view.status = STAT_FULL;
         end else begin
            pos = 0;
            if (op == OP_PUSH_BACK) begin
               pos = list_len;
            end else if (op == OP_INSERT) begin
               while (pos < list_len && list_copy[pos] < v) pos++;
            end
            for (i = list_len; i > pos; i--) list_copy[i] = list_copy[i - 1];
            list_copy[pos] = v;
            list_len++;
         end
      end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
         if (list_len == 0) begin
            view.status = STAT_EMPTY;
         end else begin
            if (op == OP_POP_FRONT) begin
               for (i = 0; i + 1 < list_len; i++) list_copy[i] = list_copy[i + 1];
            end
            list_len--;
         end
      end
      view.entry_count = list_len[COUNT_W-1:0];
      view.first_value = (list_len == 0) ? VAL_ZERO : list_copy[0];
      view.last_value  = (list_len == 0) ? VAL_ZERO : list_copy[list_len - 1];
      return view;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = VAL_MIN;
         1:       v = VAL_MAX;
         2:       v = ($urandom_range(0, 1) == 0) ? VAL_ZERO : VAL_NEG1;
         3, 4, 5: v = $urandom_range(0, 16) - 8;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [OPCODE_W-1:0] pick_push();
      logic [OPCODE_W-1:0] op;
      case ($urandom_range(0, 2))
         0:       op = OP_PUSH_FRONT;
         1:       op = OP_PUSH_BACK;
         default: op = OP_INSERT;
      endcase
      return op;
   endfunction

   task automatic add_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v, logic drain);
      list_op_type item;
      item.opcode = op;
      item.value  = v;
      item.drain  = drain;
      op_backlog.push_back(item);
   endtask

   // drive requests in bursts; hold until transfer
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (op_backlog.size() == 0 ||
                      (op_backlog[0].drain && expected_views.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_op = op_backlog.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= next_op.opcode;
            req_value  <= next_op.value;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= stall_pattern[stall_pos];
      stall_pos <= stall_pos + 1'b1;
      if (stall_pos == 4'hF) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern <= 16'hFFFF;
            1:       stall_pattern <= 16'($urandom);
            2:       stall_pattern <= 16'($urandom | $urandom);
            default: stall_pattern <= 16'($urandom & $urandom);
         endcase
      end
   end

   always @(posedge clock) begin
      list_view_type got;
      list_view_type want;
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
         got.status      = rsp_status;
         got.entry_count = rsp_entry_count;
         got.first_value = rsp_first_value;
         got.last_value  = rsp_last_value;
         if (expected_views.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: status %0d count %0d first %0d last %0d",
                        got.status, got.entry_count, $signed(got.first_value),
                        $signed(got.last_value));
         end else begin
            want = expected_views.pop_front();
            if (got.status != want.status || got.entry_count != want.entry_count ||
                got.first_value != want.first_value || got.last_value != want.last_value) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"mismatch: expected status %0d count %0d first %0d last %0d, ",
                            "got status %0d count %0d first %0d last %0d"},
                           want.status, want.entry_count, $signed(want.first_value),
                           $signed(want.last_value), got.status, got.entry_count,
                           $signed(got.first_value), $signed(got.last_value));
            end
         end
      end
      if (req_valid && req_ready)
         expected_views.push_back(apply_list_op(req_opcode, req_value));
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int counted;
      int phase_left;
      int push_bias;
      int r;
      logic [OPCODE_W-1:0] op;

      add_op(OP_POP_FRONT, $urandom, 1'b0);
      add_op(OP_POP_BACK, $urandom, 1'b0);
      add_op(OP_PUSH_FRONT, VAL_MIN, 1'b0);
      add_op(OP_POP_BACK, $urandom, 1'b0);
      add_op(OP_PUSH_BACK, VAL_MAX, 1'b0);
      add_op(OP_INSERT, VAL_ZERO, 1'b0);
      add_op(OP_INSERT, VAL_ZERO, 1'b0);
      add_op(OP_INSERT, VAL_MIN, 1'b0);
      add_op(OP_INSERT, VAL_MAX, 1'b0);
      add_op(OP_INSERT, VAL_NEG1, 1'b0);
      add_op(OP_PUSH_FRONT, 32'h5555_5555, 1'b0);
      add_op(OP_RSVD_FIRST, $urandom, 1'b0);
      add_op(OP_RSVD_MID, $urandom, 1'b0);
      add_op(OP_RSVD_LAST, $urandom, 1'b0);
      for (int k = 0; k < 9; k++) add_op(pick_push(), pick_value(), 1'b0);
      add_op(OP_PUSH_BACK, 32'hAAAA_AAAA, 1'b0);
      add_op(OP_POP_FRONT, $urandom, 1'b1);

      // phases with a random push bias, fill-heavy or drain-heavy, so both full and empty recur
      counted = 0;
      phase_left = 0;
      push_bias = 50;
      while (counted < ITEM_TARGET) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            push_bias = $urandom_range(10, 90);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            op = OP_RSVD_FIRST + OPCODE_W'($urandom_range(0, 2));
         end else begin
            counted++;
            if ($urandom_range(0, 99) < push_bias) op = pick_push();
            else op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
         end
         add_op(op, pick_value(), (counted == ITEM_TARGET / 2 && r >= 2) ||
                                  $urandom_range(0, 299) == 0);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_views.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fault_count == 0 && expected_views.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sorted_deque_list_unit.f
hw/rtl/sdl_pkg.sv
hw/rtl/sdl_ctrl.sv
hw/rtl/sdl_datapath.sv
hw/rtl/sorted_deque_list_unit.sv
hw/rtl/sdl_checker.sv
bench/tb.sv
